// ===== rtl/core/config_text_lexer_macros.svh =====
// ---------------------------------------------------------------------------
// Config text lexer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef CONFIG_TEXT_LEXER_MACROS_SVH
`define CONFIG_TEXT_LEXER_MACROS_SVH

// Property that must hold at every edge out of reset
`define CFL_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Property that must follow a trigger (non-overlapping implication)
`define CFL_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (expr)) \
    else $error(msg);

`endif

// ===== rtl/core/cfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Config text lexer package
// Lexer modes, token kinds, character constants and character classes.
// ---------------------------------------------------------------------------
package cfl_pkg;

  // Lexer mode between bytes
  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_LIST,
    MODE_CMD_WS,
    MODE_CMD_BODY,
    MODE_COMMENT,
    MODE_DASH_FIRST,
    MODE_DASH_WS,
    MODE_LIT_FIRST,
    MODE_LITERAL,
    MODE_HEX,
    MODE_IDENT,
    MODE_ZERO,
    MODE_DIGIT
  } lex_mode_e;

  // Reported token kinds
  typedef enum logic [3:0] {
    TOK_UNKNOWN,
    TOK_END,
    TOK_OPEN,
    TOK_CLOSE,
    TOK_PLUS,
    TOK_NEGATE,
    TOK_LIST,
    TOK_CMD,
    TOK_COMMENT,
    TOK_PASS,
    TOK_HEX,
    TOK_LITERAL,
    TOK_IDENT,
    TOK_DIGIT
  } tok_kind_e;

  // Control state carried between bytes
  typedef struct packed {
    lex_mode_e mode;
    logic      escape;
  } lex_ctrl_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || is_eol(c);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_num(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_num(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic is_x(input logic [7:0] c);
    return (c == CH_LO_X) || (c == CH_UP_X);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cfl_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Text byte channel
// Valid/ready channel carrying one text byte per beat.
// ---------------------------------------------------------------------------
interface cfl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cfl_token_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Token channel
// Valid/ready channel carrying one lexed token per beat.
// ---------------------------------------------------------------------------
interface cfl_token_if #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             token_kind;
  logic [OFFSET_BITS-1:0] token_start;
  logic [OFFSET_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]   line_number;
  logic                   last_of_run;

  modport source (
    output valid, output token_kind, output token_start, output token_length,
    output line_number, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input token_start, input token_length,
    input line_number, input last_of_run, output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/cfl_lex_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Lexer step
// Next lexer state and up to two tokens for one registered text byte.
// ---------------------------------------------------------------------------
module cfl_lex_step #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20
) (
  input  logic [7:0]             byte_i,
  input  cfl_pkg::lex_ctrl_t     ctrl_i,
  input  logic [OFFSET_BITS-1:0] byte_offset_i,
  input  logic [OFFSET_BITS-1:0] start_offset_i,
  input  logic [LINE_BITS-1:0]   line_count_i,
  output cfl_pkg::lex_ctrl_t     ctrl_o,
  output logic [OFFSET_BITS-1:0] byte_offset_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [LINE_BITS-1:0]   line_count_o,
  output logic [1:0]             res_n_o,
  output logic [3:0]             r0_kind_o,
  output logic [OFFSET_BITS-1:0] r0_start_o,
  output logic [OFFSET_BITS-1:0] r0_len_o,
  output logic [3:0]             r1_kind_o,
  output logic [OFFSET_BITS-1:0] r1_start_o,
  output logic [OFFSET_BITS-1:0] r1_len_o
);

  logic [OFFSET_BITS-1:0] upto_len;
  logic [OFFSET_BITS-1:0] next_offset;

  // Idle-mode decode of the byte
  logic                   idle_emit;
  cfl_pkg::tok_kind_e     idle_kind;
  cfl_pkg::lex_mode_e     idle_mode;
  logic [OFFSET_BITS-1:0] idle_start;
  logic                   idle_end;

  // Token left pending by the current mode
  logic                   pend_emit;
  cfl_pkg::tok_kind_e     pend_kind;
  logic [OFFSET_BITS-1:0] pend_start;
  logic [OFFSET_BITS-1:0] pend_len;
  logic                   go_idle;
  cfl_pkg::lex_mode_e     mode_d;
  logic                   esc_d;
  logic [OFFSET_BITS-1:0] start_d;
  logic                   line_inc;
  logic                   stream_end;

  assign upto_len    = byte_offset_i - start_offset_i;
  assign next_offset = byte_offset_i + OFFSET_BITS'(1);

  // Byte seen between tokens
  always_comb begin
    idle_emit  = 1'b0;
    idle_kind  = cfl_pkg::TOK_UNKNOWN;
    idle_mode  = cfl_pkg::MODE_IDLE;
    idle_start = start_offset_i;
    idle_end   = 1'b0;
    if (byte_i == cfl_pkg::CH_NUL) begin
      idle_emit = 1'b1;
      idle_kind = cfl_pkg::TOK_END;
      idle_end  = 1'b1;
    end else if (cfl_pkg::is_ws(byte_i)) begin
      idle_emit = 1'b0;
    end else if (byte_i == cfl_pkg::CH_LBRACE) begin
      idle_emit = 1'b1;
      idle_kind = cfl_pkg::TOK_OPEN;
    end else if (byte_i == cfl_pkg::CH_RBRACE) begin
      idle_emit = 1'b1;
      idle_kind = cfl_pkg::TOK_CLOSE;
    end else if (byte_i == cfl_pkg::CH_PLUS) begin
      idle_emit = 1'b1;
      idle_kind = cfl_pkg::TOK_PLUS;
    end else if (byte_i == cfl_pkg::CH_BANG) begin
      idle_emit = 1'b1;
      idle_kind = cfl_pkg::TOK_NEGATE;
    end else if (byte_i == cfl_pkg::CH_LBRACK) begin
      idle_start = next_offset;
      idle_mode  = cfl_pkg::MODE_LIST;
    end else if (byte_i == cfl_pkg::CH_COLON) begin
      idle_mode = cfl_pkg::MODE_CMD_WS;
    end else if (byte_i == cfl_pkg::CH_HASH) begin
      idle_start = next_offset;
      idle_mode  = cfl_pkg::MODE_COMMENT;
    end else if (byte_i == cfl_pkg::CH_DASH) begin
      idle_start = byte_offset_i;
      idle_mode  = cfl_pkg::MODE_DASH_FIRST;
    end else if (cfl_pkg::is_alpha(byte_i)) begin
      idle_start = byte_offset_i;
      idle_mode  = cfl_pkg::MODE_IDENT;
    end else if (byte_i == cfl_pkg::CH_ZERO) begin
      idle_start = byte_offset_i;
      idle_mode  = cfl_pkg::MODE_ZERO;
    end else if (cfl_pkg::is_num(byte_i)) begin
      idle_start = byte_offset_i;
      idle_mode  = cfl_pkg::MODE_DIGIT;
    end else begin
      idle_emit = 1'b1;
      idle_kind = cfl_pkg::TOK_UNKNOWN;
    end
  end

  // Mode update and pending token
  always_comb begin
    pend_emit  = 1'b0;
    pend_kind  = cfl_pkg::TOK_UNKNOWN;
    pend_start = start_offset_i;
    pend_len   = upto_len;
    go_idle    = 1'b0;
    mode_d     = ctrl_i.mode;
    esc_d      = ctrl_i.escape;
    start_d    = start_offset_i;
    line_inc   = 1'b0;
    case (ctrl_i.mode)
      cfl_pkg::MODE_LIST: begin
        if (byte_i == cfl_pkg::CH_RBRACK) begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_LIST;
          mode_d    = cfl_pkg::MODE_IDLE;
        end else if (byte_i == cfl_pkg::CH_NUL) begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_LIST;
          go_idle   = 1'b1;
        end
      end
      cfl_pkg::MODE_COMMENT: begin
        if ((byte_i == cfl_pkg::CH_NUL) || cfl_pkg::is_eol(byte_i)) begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_COMMENT;
          go_idle   = 1'b1;
        end
      end
      cfl_pkg::MODE_CMD_WS: begin
        if (byte_i == cfl_pkg::CH_NUL) begin
          // empty command at the end of the stream
          pend_emit  = 1'b1;
          pend_kind  = cfl_pkg::TOK_CMD;
          pend_start = byte_offset_i;
          pend_len   = '0;
          go_idle    = 1'b1;
        end else if (cfl_pkg::is_ws(byte_i)) begin
          line_inc = cfl_pkg::is_eol(byte_i);
        end else begin
          // first body byte: never a line end here
          start_d = byte_offset_i;
          mode_d  = cfl_pkg::MODE_CMD_BODY;
          esc_d   = (byte_i == cfl_pkg::CH_BSLASH);
        end
      end
      cfl_pkg::MODE_CMD_BODY: begin
        if (ctrl_i.escape) begin
          esc_d = 1'b0;
          if (byte_i == cfl_pkg::CH_NUL) begin
            pend_emit = 1'b1;
            pend_kind = cfl_pkg::TOK_CMD;
            go_idle   = 1'b1;
          end else begin
            line_inc = cfl_pkg::is_eol(byte_i);
          end
        end else if ((byte_i == cfl_pkg::CH_NUL) || cfl_pkg::is_eol(byte_i)) begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_CMD;
          go_idle   = 1'b1;
        end else if (byte_i == cfl_pkg::CH_BSLASH) begin
          esc_d = 1'b1;
        end
      end
      cfl_pkg::MODE_DASH_FIRST, cfl_pkg::MODE_DASH_WS: begin
        if ((ctrl_i.mode == cfl_pkg::MODE_DASH_FIRST) && (byte_i == cfl_pkg::CH_NUL)) begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_UNKNOWN;
          pend_len  = OFFSET_BITS'(1);
          go_idle   = 1'b1;
        end else if ((ctrl_i.mode == cfl_pkg::MODE_DASH_FIRST) &&
                     (byte_i == cfl_pkg::CH_GT)) begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_PASS;
          pend_len  = OFFSET_BITS'(2);
          mode_d    = cfl_pkg::MODE_IDLE;
        end else if (cfl_pkg::is_ws(byte_i)) begin
          line_inc = cfl_pkg::is_eol(byte_i);
          mode_d   = cfl_pkg::MODE_DASH_WS;
        end else if (cfl_pkg::is_alnum(byte_i)) begin
          start_d = byte_offset_i;
          mode_d  = cfl_pkg::MODE_LIT_FIRST;
        end else begin
          // dash without a word: unknown at this byte, then relex it
          pend_emit  = 1'b1;
          pend_kind  = cfl_pkg::TOK_UNKNOWN;
          pend_start = byte_offset_i;
          pend_len   = OFFSET_BITS'(1);
          go_idle    = 1'b1;
        end
      end
      cfl_pkg::MODE_LIT_FIRST: begin
        if (cfl_pkg::is_x(byte_i)) begin
          mode_d = cfl_pkg::MODE_HEX;
        end else if (cfl_pkg::is_alnum(byte_i)) begin
          mode_d = cfl_pkg::MODE_LITERAL;
        end else begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_LITERAL;
          go_idle   = 1'b1;
        end
      end
      cfl_pkg::MODE_LITERAL: begin
        if (!cfl_pkg::is_alnum(byte_i)) begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_LITERAL;
          go_idle   = 1'b1;
        end
      end
      cfl_pkg::MODE_HEX: begin
        if (!cfl_pkg::is_hex(byte_i)) begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_HEX;
          go_idle   = 1'b1;
        end
      end
      cfl_pkg::MODE_IDENT: begin
        if (!cfl_pkg::is_alnum(byte_i)) begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_IDENT;
          go_idle   = 1'b1;
        end
      end
      cfl_pkg::MODE_ZERO: begin
        if (cfl_pkg::is_x(byte_i)) begin
          mode_d = cfl_pkg::MODE_HEX;
        end else if (cfl_pkg::is_num(byte_i) || (byte_i == cfl_pkg::CH_DOT)) begin
          mode_d = cfl_pkg::MODE_DIGIT;
        end else begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_DIGIT;
          go_idle   = 1'b1;
        end
      end
      cfl_pkg::MODE_DIGIT: begin
        if (!(cfl_pkg::is_num(byte_i) || (byte_i == cfl_pkg::CH_DOT))) begin
          pend_emit = 1'b1;
          pend_kind = cfl_pkg::TOK_DIGIT;
          go_idle   = 1'b1;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    // byte relexed as if between tokens
    if (go_idle) begin
      mode_d   = idle_mode;
      esc_d    = 1'b0;
      start_d  = idle_start;
      line_inc = cfl_pkg::is_eol(byte_i);
    end
    stream_end = go_idle && idle_end;
  end

  // Results: pending token first, then the idle token
  always_comb begin
    res_n_o    = {1'b0, pend_emit} + {1'b0, go_idle && idle_emit};
    r1_kind_o  = idle_kind;
    r1_start_o = byte_offset_i;
    r1_len_o   = OFFSET_BITS'(1);
    if (pend_emit) begin
      r0_kind_o  = pend_kind;
      r0_start_o = pend_start;
      r0_len_o   = pend_len;
    end else begin
      r0_kind_o  = idle_kind;
      r0_start_o = byte_offset_i;
      r0_len_o   = OFFSET_BITS'(1);
    end
  end

  // Next state; end of stream returns everything to reset values
  always_comb begin
    if (stream_end) begin
      ctrl_o.mode    = cfl_pkg::MODE_IDLE;
      ctrl_o.escape  = 1'b0;
      byte_offset_o  = '0;
      start_offset_o = '0;
      line_count_o   = '0;
    end else begin
      ctrl_o.mode    = mode_d;
      ctrl_o.escape  = esc_d;
      byte_offset_o  = next_offset;
      start_offset_o = start_d;
      line_count_o   = line_count_i + LINE_BITS'(line_inc);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cfl_res_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Result queue
// Small register queue taking up to two tokens per cycle, giving one.
// ---------------------------------------------------------------------------
module cfl_res_fifo #(
  parameter int WIDTH = 74,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_n_i,
  input  logic [WIDTH-1:0]           wdata0_i,
  input  logic [WIDTH-1:0]           wdata1_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic [PTR_W-1:0] wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
  assign rdata_o   = mem_q[rd_ptr_q];
  assign level_o   = level_q;

  // Pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_n_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop_i);
    level_d  = level_q + LVL_W'(push_n_i) - LVL_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wdata0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= wdata1_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/config_text_lexer.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "config_text_lexer_macros.svh"
// Path: a byte is registered at its accepting edge and lexed once the result queue has
//   room for two tokens; its tokens are written into the four-entry result queue.
// Throughput: one byte per cycle while the queue has room for two; a byte that ends
//   one token and starts another gives two output beats, taken one per ready cycle.
// Reset: rst_ni clears mode, offsets, line counter and the queue at once;
//   a zero byte (end of stream) returns the lexer state to the same values.
// ---------------------------------------------------------------------------
// Config text lexer
// Streaming tokeniser for a small configuration language, one byte per beat.
// ---------------------------------------------------------------------------
module config_text_lexer #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfl_byte_if.sink    byte_i,
  cfl_token_if.source token_o
);

  localparam int RES_DEPTH = 4;
  localparam int LVL_W     = $clog2(RES_DEPTH + 1);
  localparam int RES_W     = 4 + 2 * OFFSET_BITS + LINE_BITS + 1;

  // Input register
  logic [7:0] byte_q;
  logic       in_valid_q;
  logic       proceed;

  // Lexer state
  cfl_pkg::lex_ctrl_t     ctrl_q, ctrl_d;
  logic [OFFSET_BITS-1:0] byte_offset_q, byte_offset_d;
  logic [OFFSET_BITS-1:0] start_offset_q, start_offset_d;
  logic [LINE_BITS-1:0]   line_q, line_d;

  // Step results
  logic [1:0]             res_n;
  logic [3:0]             r0_kind, r1_kind;
  logic [OFFSET_BITS-1:0] r0_start, r0_len, r1_start, r1_len;
  logic [1:0]             push_n;
  logic [RES_W-1:0]       wdata0, wdata1, rdata;
  logic [LVL_W-1:0]       level;
  logic                   pop;

  // Work on the held byte when the queue has room for two tokens
  assign proceed      = in_valid_q && (level <= LVL_W'(RES_DEPTH - 2));
  assign byte_i.ready = !in_valid_q || proceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (proceed) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      byte_q <= byte_i.text_byte;
    end
  end

  cfl_lex_step #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_step (
    .byte_i         (byte_q),
    .ctrl_i         (ctrl_q),
    .byte_offset_i  (byte_offset_q),
    .start_offset_i (start_offset_q),
    .line_count_i   (line_q),
    .ctrl_o         (ctrl_d),
    .byte_offset_o  (byte_offset_d),
    .start_offset_o (start_offset_d),
    .line_count_o   (line_d),
    .res_n_o        (res_n),
    .r0_kind_o      (r0_kind),
    .r0_start_o     (r0_start),
    .r0_len_o       (r0_len),
    .r1_kind_o      (r1_kind),
    .r1_start_o     (r1_start),
    .r1_len_o       (r1_len)
  );

  // Lexer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.mode    <= cfl_pkg::MODE_IDLE;
      ctrl_q.escape  <= 1'b0;
      byte_offset_q  <= '0;
      start_offset_q <= '0;
      line_q         <= '0;
    end else if (proceed) begin
      ctrl_q         <= ctrl_d;
      byte_offset_q  <= byte_offset_d;
      start_offset_q <= start_offset_d;
      line_q         <= line_d;
    end
  end

  // Token packing; the last token of a byte carries the run flag
  assign push_n = proceed ? res_n : 2'd0;
  assign wdata0 = {r0_kind, r0_start, r0_len, line_q, (res_n == 2'd1)};
  assign wdata1 = {r1_kind, r1_start, r1_len, line_q, 1'b1};

  assign pop = token_o.valid && token_o.ready;

  cfl_res_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .wdata0_i (wdata0),
    .wdata1_i (wdata1),
    .pop_i    (pop),
    .rdata_o  (rdata),
    .level_o  (level)
  );

  assign token_o.valid = (level != '0);
  assign {token_o.token_kind, token_o.token_start, token_o.token_length,
          token_o.line_number, token_o.last_of_run} = rdata;

  // Checks
  `CFL_ASSERT(a_queue_bound, level <= LVL_W'(RES_DEPTH), "result queue overfilled")
  `CFL_ASSERT(a_end_gives_token, !(proceed && (byte_q == cfl_pkg::CH_NUL)) || (res_n != 2'd0),
              "end of stream gave no token")
  `CFL_ASSERT_NEXT(a_end_clears, proceed && (byte_q == cfl_pkg::CH_NUL),
                   (byte_offset_q == '0) && (line_q == '0) &&
                   (ctrl_q.mode == cfl_pkg::MODE_IDLE),
                   "lexer state not cleared after end of stream")
  `CFL_ASSERT_NEXT(a_offset_step, proceed && (byte_q != cfl_pkg::CH_NUL),
                   byte_offset_q == OFFSET_BITS'($past(byte_offset_q) + OFFSET_BITS'(1)),
                   "byte offset did not advance by one")

endmodule
`default_nettype wire

// ===== tb/config_text_lexer_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Config text lexer token checker
// Watches both channels, keeps its own lexer state, works out the tokens
// each accepted byte should give and compares every token beat against them.
// ---------------------------------------------------------------------------
module config_text_lexer_checker
  import cfl_pkg::*;
#(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   byte_valid_i,
  input  logic                   byte_ready_i,
  input  logic [7:0]             text_byte_i,
  input  logic                   tok_valid_i,
  input  logic                   tok_ready_i,
  input  logic [3:0]             token_kind_i,
  input  logic [OFFSET_BITS-1:0] token_start_i,
  input  logic [OFFSET_BITS-1:0] token_length_i,
  input  logic [LINE_BITS-1:0]   line_number_i,
  input  logic                   last_of_run_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    tok_kind_e              kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic                   last;
  } token_t;

  // Shadow lexer state
  lex_mode_e              mode_q      = MODE_IDLE;
  logic [OFFSET_BITS-1:0] pos_q       = '0;
  logic [OFFSET_BITS-1:0] tok_start_q = '0;
  logic [LINE_BITS-1:0]   line_q      = '0;
  logic                   esc_q       = 1'b0;
  logic                   stream_done;

  // Tokens raised by the byte in hand, then the ones still owed by the DUT
  token_t run_toks [2];
  int     run_n;
  token_t expected_tokens [$];

  // Character classes
  function automatic bit line_end(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic bit space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || line_end(c);
  endfunction

  function automatic bit numeral(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return numeral(c) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic bit x_char(input logic [7:0] c);
    return (c == CH_LO_X) || (c == CH_UP_X);
  endfunction

  function automatic void reset_state();
    mode_q      = MODE_IDLE;
    pos_q       = '0;
    tok_start_q = '0;
    line_q      = '0;
    esc_q       = 1'b0;
  endfunction

  function automatic void count_eol(input logic [7:0] c);
    if (line_end(c)) line_q = line_q + 1'b1;
  endfunction

  // At most two tokens per byte
  function automatic void note_token(input tok_kind_e kind,
                                     input logic [OFFSET_BITS-1:0] start,
                                     input logic [OFFSET_BITS-1:0] len);
    if (run_n < 2) begin
      run_toks[run_n] = '{kind, start, len, line_q, 1'b0};
      run_n++;
    end
  endfunction

  // Token running from its start up to, not including, the current byte
  function automatic void note_upto(input tok_kind_e kind);
    note_token(kind, tok_start_q, pos_q - tok_start_q);
  endfunction

  // Byte seen between tokens
  function automatic void restart(input logic [7:0] c);
    mode_q = MODE_IDLE;
    esc_q  = 1'b0;
    if (c == CH_NUL) begin
      note_token(TOK_END, pos_q, 1);
      stream_done = 1'b1;
    end else if (space(c)) begin
      count_eol(c);
    end else if (c == CH_LBRACE) begin
      note_token(TOK_OPEN, pos_q, 1);
    end else if (c == CH_RBRACE) begin
      note_token(TOK_CLOSE, pos_q, 1);
    end else if (c == CH_PLUS) begin
      note_token(TOK_PLUS, pos_q, 1);
    end else if (c == CH_BANG) begin
      note_token(TOK_NEGATE, pos_q, 1);
    end else if (c == CH_LBRACK) begin
      tok_start_q = pos_q + 1'b1;
      mode_q      = MODE_LIST;
    end else if (c == CH_COLON) begin
      mode_q = MODE_CMD_WS;
    end else if (c == CH_HASH) begin
      tok_start_q = pos_q + 1'b1;
      mode_q      = MODE_COMMENT;
    end else if (c == CH_DASH) begin
      tok_start_q = pos_q;
      mode_q      = MODE_DASH_FIRST;
    end else if (word_char(c) && !numeral(c)) begin
      tok_start_q = pos_q;
      mode_q      = MODE_IDENT;
    end else if (c == CH_ZERO) begin
      tok_start_q = pos_q;
      mode_q      = MODE_ZERO;
    end else if (numeral(c)) begin
      tok_start_q = pos_q;
      mode_q      = MODE_DIGIT;
    end else begin
      note_token(TOK_UNKNOWN, pos_q, 1);
    end
  endfunction

  // Command body: runs to end of line, backslash escapes the next byte
  function automatic void cmd_char(input logic [7:0] c);
    if (esc_q) begin
      esc_q = 1'b0;
      if (c == CH_NUL) begin
        note_upto(TOK_CMD);
        restart(c);
      end else begin
        count_eol(c);
      end
    end else if ((c == CH_NUL) || line_end(c)) begin
      note_upto(TOK_CMD);
      restart(c);
    end else if (c == CH_BSLASH) begin
      esc_q = 1'b1;
    end
  endfunction

  // After a dash: whitespace, then a word or else an unknown byte
  function automatic void dash_char(input logic [7:0] c);
    if (space(c)) begin
      count_eol(c);
      mode_q = MODE_DASH_WS;
    end else if (word_char(c)) begin
      tok_start_q = pos_q;
      mode_q      = MODE_LIT_FIRST;
    end else begin
      note_token(TOK_UNKNOWN, pos_q, 1);
      restart(c);
    end
  endfunction

  // Advance the shadow lexer by one byte and queue the tokens it gives
  function automatic void lex_byte(input logic [7:0] c);
    run_n       = 0;
    stream_done = 1'b0;
    case (mode_q)
      MODE_LIST: begin
        if (c == CH_RBRACK) begin
          note_upto(TOK_LIST);
          mode_q = MODE_IDLE;
        end else if (c == CH_NUL) begin
          note_upto(TOK_LIST);
          restart(c);
        end
      end
      MODE_COMMENT: begin
        if ((c == CH_NUL) || line_end(c)) begin
          note_upto(TOK_COMMENT);
          restart(c);
        end
      end
      MODE_CMD_WS: begin
        if (c == CH_NUL) begin
          tok_start_q = pos_q;
          note_upto(TOK_CMD);
          restart(c);
        end else if (space(c)) begin
          count_eol(c);
        end else begin
          tok_start_q = pos_q;
          mode_q      = MODE_CMD_BODY;
          esc_q       = 1'b0;
          cmd_char(c);
        end
      end
      MODE_CMD_BODY: cmd_char(c);
      MODE_DASH_FIRST: begin
        if (c == CH_NUL) begin
          note_token(TOK_UNKNOWN, tok_start_q, 1);
          restart(c);
        end else if (c == CH_GT) begin
          note_token(TOK_PASS, tok_start_q, 2);
          mode_q = MODE_IDLE;
        end else begin
          dash_char(c);
        end
      end
      MODE_DASH_WS: dash_char(c);
      MODE_LIT_FIRST: begin
        if (x_char(c)) begin
          mode_q = MODE_HEX;
        end else if (word_char(c)) begin
          mode_q = MODE_LITERAL;
        end else begin
          note_upto(TOK_LITERAL);
          restart(c);
        end
      end
      MODE_LITERAL: begin
        if (!word_char(c)) begin
          note_upto(TOK_LITERAL);
          restart(c);
        end
      end
      MODE_HEX: begin
        if (!(numeral(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
              ((c >= CH_UP_A) && (c <= CH_UP_F)))) begin
          note_upto(TOK_HEX);
          restart(c);
        end
      end
      MODE_IDENT: begin
        if (!word_char(c)) begin
          note_upto(TOK_IDENT);
          restart(c);
        end
      end
      MODE_ZERO: begin
        if (x_char(c)) begin
          mode_q = MODE_HEX;
        end else if (numeral(c) || (c == CH_DOT)) begin
          mode_q = MODE_DIGIT;
        end else begin
          note_upto(TOK_DIGIT);
          restart(c);
        end
      end
      MODE_DIGIT: begin
        if (!(numeral(c) || (c == CH_DOT))) begin
          note_upto(TOK_DIGIT);
          restart(c);
        end
      end
      default: restart(c);
    endcase

    if (run_n > 0) run_toks[run_n-1].last = 1'b1;
    for (int i = 0; i < run_n; i++) expected_tokens.push_back(run_toks[i]);

    // End of stream returns everything to its reset value
    if (stream_done) reset_state();
    else pos_q = pos_q + 1'b1;
  endfunction

  // Predict on byte beats, compare on token beats
  always @(posedge clk_i or negedge rst_ni) begin : watch_beats
    token_t want;
    if (!rst_ni) begin
      reset_state();
      expected_tokens.delete();
    end else begin
      if (byte_valid_i && byte_ready_i) lex_byte(text_byte_i);
      if (tok_valid_i && tok_ready_i) begin
        if (expected_tokens.size() == 0) begin
          $error("token beat with nothing expected: kind %0d start %0d length %0d",
                 token_kind_i, token_start_i, token_length_i);
          fail_count_o++;
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind_i !== want.kind) begin
            $error("token_kind: expected %0d (%s), got %0d",
                   want.kind, want.kind.name(), token_kind_i);
            fail_count_o++;
          end
          if (token_start_i !== want.start) begin
            $error("token_start: expected %0d, got %0d", want.start, token_start_i);
            fail_count_o++;
          end
          if (token_length_i !== want.len) begin
            $error("token_length: expected %0d, got %0d", want.len, token_length_i);
            fail_count_o++;
          end
          if (line_number_i !== want.line) begin
            $error("line_number: expected %0d, got %0d", want.line, line_number_i);
            fail_count_o++;
          end
          if (last_of_run_i !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, last_of_run_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_tokens.size();
  end

endmodule

// ===== tb/config_text_lexer_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Config text lexer testbench
// Feeds short directed text then random token streams or raw noise, each closed by a
// zero byte, with random gaps and stalls on both channels; the checker
// alongside the DUT predicts and compares every token beat.
// ---------------------------------------------------------------------------
module config_text_lexer_tb;
  import cfl_pkg::*;

  localparam int OFS_W        = 24;
  localparam int LIN_W        = 20;
  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_ITEMS = 1200;
  localparam int LONG_HOLD    = 120;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int LIMIT_CYCLES = 200000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cfl_byte_if byte_if ();
  cfl_token_if #(.OFFSET_BITS(OFS_W), .LINE_BITS(LIN_W)) tok_if ();

  int tokens_failed;
  int tokens_pending;
  bit burst_mode;
  int bytes_sent;

  config_text_lexer #(
    .OFFSET_BITS (OFS_W),
    .LINE_BITS   (LIN_W)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .token_o (tok_if)
  );

  config_text_lexer_checker #(
    .OFFSET_BITS (OFS_W),
    .LINE_BITS   (LIN_W)
  ) token_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (byte_if.valid),
    .byte_ready_i   (byte_if.ready),
    .text_byte_i    (byte_if.text_byte),
    .tok_valid_i    (tok_if.valid),
    .tok_ready_i    (tok_if.ready),
    .token_kind_i   (tok_if.token_kind),
    .token_start_i  (tok_if.token_start),
    .token_length_i (tok_if.token_length),
    .line_number_i  (tok_if.line_number),
    .last_of_run_i  (tok_if.last_of_run),
    .fail_count_o   (tokens_failed),
    .pending_o      (tokens_pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Random character pickers
  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VT;
      3:       return CH_FF;
      4:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] rand_eol();
    return ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
  endfunction

  function automatic logic [7:0] rand_word(input bit letters_only);
    int r;
    r = $urandom_range(0, letters_only ? 51 : 61);
    if (r < 26) return CH_LO_A + r;
    else if (r < 52) return CH_UP_A + (r - 26);
    else return CH_ZERO + (r - 52);
  endfunction

  function automatic logic [7:0] rand_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return CH_ZERO + r;
    else if (r < 16) return CH_LO_A + (r - 10);
    else return CH_UP_A + (r - 16);
  endfunction

  // Any non-zero byte that does not end a line
  function automatic logic [7:0] rand_body();
    logic [7:0] b;
    b = $urandom_range(1, 255);
    return ((b == CH_CR) || (b == CH_LF)) ? CH_SPACE : b;
  endfunction

  // One byte beat; valid stays high across back-to-back beats
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.text_byte <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
  endtask

  task automatic send_ws(input int n);
    repeat (n) send_byte(rand_ws());
  endtask

  // One token of random kind and content, occasionally malformed
  task automatic send_token();
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0: begin
        case ($urandom_range(0, 3))
          0:       send_byte(CH_LBRACE);
          1:       send_byte(CH_RBRACE);
          2:       send_byte(CH_PLUS);
          default: send_byte(CH_BANG);
        endcase
      end
      1: begin
        send_byte(CH_LBRACK);
        repeat ($urandom_range(0, 5)) begin
          b = $urandom_range(1, 255);
          send_byte((b == CH_RBRACK) ? CH_SPACE : b);
        end
        if ($urandom_range(0, 7) != 0) send_byte(CH_RBRACK);
      end
      2: begin
        send_byte(CH_COLON);
        send_ws($urandom_range(0, 2));
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) begin
            send_byte(CH_BSLASH);
            send_byte($urandom_range(1, 255));
          end else begin
            send_byte(rand_body());
          end
        end
        // mostly a line end; now and then a dangling escape or nothing
        case ($urandom_range(0, 9))
          0:       send_byte(CH_BSLASH);
          1:       ;
          default: send_byte(rand_eol());
        endcase
      end
      3: begin
        send_byte(CH_HASH);
        repeat ($urandom_range(0, 8)) send_byte(rand_body());
        send_byte(rand_eol());
      end
      4: begin
        send_byte(CH_DASH);
        send_byte(CH_GT);
      end
      5: begin
        // dash-led literal or dash-led hex
        send_byte(CH_DASH);
        send_ws($urandom_range(0, 1));
        if ($urandom_range(0, 2) == 0) begin
          send_byte(CH_ZERO);
          send_byte(($urandom_range(0, 1) != 0) ? CH_LO_X : CH_UP_X);
          repeat ($urandom_range(0, 4)) send_byte(rand_hex());
        end else begin
          repeat ($urandom_range(1, 5)) send_byte(rand_word(1'b0));
        end
      end
      6: begin
        // dash with no word after it
        send_byte(CH_DASH);
        send_ws($urandom_range(0, 2));
        if ($urandom_range(0, 2) == 0) begin
          send_byte(CH_GT);
        end else begin
          b = $urandom_range(1, 255);
          if (((b >= CH_ZERO) && (b <= CH_NINE)) || ((b >= CH_LO_A) && (b <= CH_LO_Z)) ||
              ((b >= CH_UP_A) && (b <= CH_UP_Z))) b = CH_DOT;
          send_byte(b);
        end
      end
      7, 8: begin
        send_byte(rand_word(1'b1));
        repeat ($urandom_range(0, 6)) send_byte(rand_word(1'b0));
      end
      9: begin
        send_byte(CH_ZERO);
        send_byte(($urandom_range(0, 1) != 0) ? CH_LO_X : CH_UP_X);
        repeat ($urandom_range(0, 4)) send_byte(rand_hex());
      end
      10: begin
        send_byte($urandom_range(CH_ZERO, CH_NINE));
        repeat ($urandom_range(0, 5)) begin
          send_byte(($urandom_range(0, 3) == 0) ? CH_DOT : $urandom_range(CH_ZERO, CH_NINE));
        end
      end
      default: send_byte($urandom_range(1, 255));
    endcase
  endtask

  // A stream of tokens, or of raw noise, closed by a zero byte
  task automatic send_stream();
    burst_mode = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(4, 16)) send_byte($urandom_range(1, 255));
    end else begin
      repeat ($urandom_range(1, 24)) begin
        send_token();
        send_ws(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2));
      end
    end
    send_byte(CH_NUL);
  endtask

  // Token sink: random stalls, steady stretches and a long hold-off now and then
  initial begin : token_sink
    int stall;
    int beats_taken;
    bit steady;
    beats_taken = 0;
    steady      = 1'b0;
    tok_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 7);
      if (beats_taken % 300 == 40) stall = LONG_HOLD;
      if (stall > 0) begin
        tok_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      tok_if.ready <= 1'b1;
      do @(posedge clk_i); while (!tok_if.valid);
      beats_taken++;
    end
  end

  // Stimulus and verdict
  initial begin : byte_source
    logic [7:0] opening_text [$];
    int drain_cycles;
    byte_if.valid     <= 1'b0;
    byte_if.text_byte <= CH_NUL;
    bytes_sent = 0;
    burst_mode = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every token kind, all-ones and zero bytes, CR line end, dash hex ended
    // by an unknown byte, escaped end of stream, dash at end of stream
    opening_text = '{CH_LBRACE, CH_RBRACE, CH_PLUS, CH_BANG, CH_LBRACK, CH_RBRACK,
                     CH_HASH, CH_LF, CH_DASH, CH_GT, CH_DASH, CH_ZERO, CH_LO_X, CH_UP_F,
                     8'hFF, CH_DASH, CH_LO_A, CH_CR, CH_LO_F, CH_COLON, CH_BSLASH, CH_NUL,
                     CH_ZERO, CH_DOT, CH_NINE, CH_DASH, CH_NUL};
    foreach (opening_text[i]) send_byte(opening_text[i]);

    while (bytes_sent < RANDOM_ITEMS + opening_text.size()) send_stream();
    byte_if.valid <= 1'b0;

    // Let the remaining tokens drain, then give the verdict
    drain_cycles = 0;
    do begin
      @(negedge clk_i);
      drain_cycles++;
    end while ((tokens_pending != 0) && (drain_cycles < DRAIN_LIMIT));
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);

    if (tokens_pending != 0) $error("%0d expected tokens never arrived", tokens_pending);
    if ((tokens_failed == 0) && (tokens_pending == 0)) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("== FAIL ==");
    $finish;
  end

endmodule
